/* sv/mtrc_pkg.sv */
// mtrc_pkg: types and constants for the modbus tcp response checker
// no dependencies; imported by modbus_tcp_response_checker_core
`default_nettype none

package mtrc_pkg;

  localparam int unsigned PosW        = 17;
  localparam int unsigned SizeW       = PosW + 1;
  localparam int unsigned HeadBytes   = 9;
  localparam int unsigned HeadIdxW    = 4;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [PosW-1:0]  PosMax       = '1;
  localparam logic [PosW-1:0]  MinFrame     = 17'd9;
  localparam logic [PosW-1:0]  PayloadStart = 17'd8;
  localparam logic [SizeW-1:0] MbapOverhead = 18'd6;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_TIMEOUT   = 4'd1,
    ST_SHORT     = 4'd2,
    ST_TXID      = 4'd3,
    ST_PROTOCOL  = 4'd4,
    ST_LENGTH    = 4'd5,
    ST_UNIT      = 4'd6,
    ST_EXCEPTION = 4'd7,
    ST_FUNCTION  = 4'd8
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRANSACTION = 2'd0,
    CFG_UNIT        = 2'd1,
    CFG_FUNCTION    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       is_final;
    status_e    status;
    logic [7:0] exception_code;
  } result_t;

endpackage

`default_nettype wire

/* sv/modbus_tcp_response_checker_core.sv */
// modbus tcp response checker: one received frame byte per word in, payload
// and final status out; depends on mtrc_pkg
`default_nettype none

// Takes one received byte per cycle while the skid stage is empty; the word
// with tlast set, or a word with tuser set (receive timeout), closes the frame
// and yields the final status. Bytes from frame offset 8 on are passed out at
// once as tentative payload; keep them only if the final status is ok. Results
// go to the output register, or to the one-word skid stage while it is held;
// the header check is combinational. tready stays high while one result waits
// downstream. The user must write configuration only between frames or while
// no result is pending; the core does not enforce it.
module modbus_tcp_response_checker_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [mtrc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [mtrc_pkg::CfgDataW-1:0] cfg_data_i,
  // received bytes
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  input  wire logic                          s_axis_tlast,  // frame_end
  input  wire logic                          s_axis_tuser,  // receive_timeout
  // results
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [7:0] payload_byte, [11:8] status, [19:12] exception_code, [23:20] zero
  output      logic [23:0]                   m_axis_tdata,
  output      logic                          m_axis_tlast,  // is_final
  output      logic                          m_axis_tuser   // payload_valid
);
  import mtrc_pkg::*;

  // configuration
  logic [15:0] exp_txid_q;
  logic [7:0]  exp_unit_q;
  logic [6:0]  exp_func_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_txid_q <= '0;
      exp_unit_q <= '0;
      exp_func_q <= 7'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TRANSACTION: exp_txid_q <= cfg_data_i;
        CFG_UNIT:        exp_unit_q <= cfg_data_i[7:0];
        CFG_FUNCTION:    exp_func_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // frame state
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      head_q [HeadBytes];
  logic [7:0]      h      [HeadBytes];

  logic in_acc;
  logic empty, last;
  logic [7:0] rx;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign empty  = s_axis_tuser;
  assign last   = s_axis_tlast;
  assign rx     = s_axis_tdata;

  // header as it stands including the current byte
  always_comb begin
    for (int k = 0; k < HeadBytes; k++) begin
      h[k] = (!empty && pos_q == PosW'(k)) ? rx : head_q[k];
    end
  end

  logic [SizeW-1:0] size;
  logic [15:0]      txid, proto, len;
  logic             fin, pv;
  result_t          res;

  assign size  = empty ? {1'b0, pos_q} : {1'b0, pos_q} + SizeW'(1);
  assign txid  = {h[0], h[1]};
  assign proto = {h[2], h[3]};
  assign len   = {h[4], h[5]};
  assign fin   = empty || last;
  assign pv    = !empty && (pos_q >= PayloadStart);

  // checks in priority order
  always_comb begin
    res                = '0;
    res.payload_valid  = pv;
    res.payload_byte   = pv ? rx : 8'd0;
    res.is_final       = fin;
    res.status         = ST_OK;
    res.exception_code = 8'd0;
    if (fin) begin
      if (size == '0) begin
        res.status = ST_TIMEOUT;
      end else if (size < {1'b0, MinFrame}) begin
        res.status = ST_SHORT;
      end else if (txid != exp_txid_q) begin
        res.status = ST_TXID;
      end else if (proto != 16'd0) begin
        res.status = ST_PROTOCOL;
      end else if (({2'b00, len} + MbapOverhead) != size) begin
        res.status = ST_LENGTH;
      end else if (h[6] != exp_unit_q) begin
        res.status = ST_UNIT;
      end else if (h[7] == {1'b1, exp_func_q}) begin
        res.status         = ST_EXCEPTION;
        res.exception_code = h[8];
      end else if (h[7] != {1'b0, exp_func_q}) begin
        res.status = ST_FUNCTION;
      end
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (in_acc) begin
      if (fin) begin
        pos_d = '0;
      end else if (pos_q != PosMax) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // header bytes are always written before they are read
  always_ff @(posedge clk_i) begin
    if (in_acc && !empty && pos_q < PosW'(HeadBytes)) begin
      head_q[pos_q[HeadIdxW-1:0]] <= rx;
    end
  end

  // output register with skid stage
  logic    ov_q, sv_q;
  result_t od_q, sd_q;
  logic    out_ready, new_res;

  assign out_ready     = m_axis_tready || !ov_q;
  assign new_res       = in_acc && (fin || pv);
  assign s_axis_tready = !sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      if (sv_q) begin
        if (out_ready) begin
          ov_q <= 1'b1;
          sv_q <= 1'b0;
        end
      end else if (new_res) begin
        if (out_ready) begin
          ov_q <= 1'b1;
        end else begin
          sv_q <= 1'b1;
        end
      end else if (out_ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (out_ready) od_q <= sd_q;
    end else if (new_res) begin
      if (out_ready) od_q <= res;
      else           sd_q <= res;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'd0, od_q.exception_code, od_q.status, od_q.payload_byte};
  assign m_axis_tlast  = od_q.is_final;
  assign m_axis_tuser  = od_q.payload_valid;

`ifndef SYNTHESIS
  a_skid_implies_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q)
    else $error("skid stage holds a word while the output register is empty");

  a_final_clears_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && fin) |=> (pos_q == '0))
    else $error("frame position not cleared after a closing word");

  a_status_only_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !od_q.is_final) |-> (od_q.status == ST_OK && od_q.exception_code == 8'd0))
    else $error("status given on a word that does not close the frame");

  a_exc_only_exception : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && od_q.exception_code != 8'd0) |-> (od_q.status == ST_EXCEPTION))
    else $error("exception code without exception status");

  a_payload_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !empty && !last && pos_q < PayloadStart) |-> !new_res)
    else $error("result produced for a header byte");
`endif

endmodule

`default_nettype wire

/* test/tb.sv */
// tb: self-checking bench for modbus_tcp_response_checker_core, random frames with
// random gaps on both streams, predicted results compared word by word
// depends on mtrc_pkg and modbus_tcp_response_checker_core
`timescale 1ns / 1ps

module tb;
  import mtrc_pkg::*;

  localparam int unsigned StuckLimit = 1000;
  localparam int unsigned RandomWords = 1550;

  typedef enum int {
    FLAW_NONE,
    FLAW_TXID,
    FLAW_PROTOCOL,
    FLAW_LENGTH,
    FLAW_UNIT,
    FLAW_EXCEPTION,
    FLAW_FUNCTION
  } flaw_e;

  typedef struct packed {
    logic [7:0] rx;
    logic       fin;
    logic       empty;
  } rx_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_TRANSACTION;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;

  modbus_tcp_response_checker_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  rx_word_t    rx_backlog[$];
  result_t     out_words_due[$];
  int unsigned words_queued = 0;
  int unsigned mismatches = 0;
  int unsigned stuck_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;

  // register copies and frame state of the predictor
  logic [15:0]     want_txid = 16'd0;
  logic [7:0]      want_unit = 8'd0;
  logic [6:0]      want_fn = 7'd1;
  logic [PosW-1:0] frame_pos = '0;
  logic [7:0]      rx_head [0:HeadBytes-1] = '{default: 8'h00};

  function automatic int unsigned draw_wait();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic status_e frame_status(input logic [SizeW-1:0] size,
                                           output logic [7:0] exc);
    exc = 8'h00;
    if (size == '0) return ST_TIMEOUT;
    if (size < MinFrame) return ST_SHORT;
    if ({rx_head[0], rx_head[1]} != want_txid) return ST_TXID;
    if ({rx_head[2], rx_head[3]} != 16'h0000) return ST_PROTOCOL;
    if ({2'b00, rx_head[4], rx_head[5]} != size - MbapOverhead) return ST_LENGTH;
    if (rx_head[6] != want_unit) return ST_UNIT;
    if (rx_head[7] == {1'b1, want_fn}) begin
      exc = rx_head[8];
      return ST_EXCEPTION;
    end
    if (rx_head[7] != {1'b0, want_fn}) return ST_FUNCTION;
    return ST_OK;
  endfunction

  task automatic predict_response(input logic [7:0] rx, input logic fin, input logic empty);
    result_t    r;
    logic [7:0] exc;
    r = '0;
    exc = 8'h00;
    if (empty) begin
      r.is_final = 1'b1;
      r.status = frame_status({1'b0, frame_pos}, exc);
    end else begin
      if (frame_pos < MinFrame) rx_head[frame_pos[HeadIdxW-1:0]] = rx;
      if (frame_pos >= PayloadStart) begin
        r.payload_valid = 1'b1;
        r.payload_byte = rx;
      end
      if (fin) begin
        r.is_final = 1'b1;
        r.status = frame_status({1'b0, frame_pos} + 18'd1, exc);
      end else if (frame_pos != PosMax) begin
        frame_pos = frame_pos + 1'b1;
      end
    end
    r.exception_code = exc;
    if (r.is_final) begin
      frame_pos = '0;
      foreach (rx_head[k]) rx_head[k] = 8'h00;
    end
    if (r.is_final || r.payload_valid) out_words_due.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // input side: one word at a time out of the backlog, random gap before each
  always @(negedge clk_i) begin : drive_rx
    rx_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (rx_backlog.size() > 0) begin
        w = rx_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w.rx;
        s_axis_tlast <= w.fin;
        s_axis_tuser <= w.empty;
        gap_left = draw_wait();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side: a random stall after each accepted result
  always @(negedge clk_i) begin : drive_ready
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (out_fire) stall_left = draw_wait();
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : score
    result_t want;
    if (rst_ni) begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      out_fire <= m_axis_tvalid && m_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        predict_response(s_axis_tdata, s_axis_tlast, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (out_words_due.size() == 0) begin
          $error("unexpected result word, tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = out_words_due.pop_front();
          check_field("payload_valid", want.payload_valid, m_axis_tuser);
          check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
          check_field("is_final", want.is_final, m_axis_tlast);
          check_field("status", want.status, m_axis_tdata[11:8]);
          check_field("exception_code", want.exception_code, m_axis_tdata[19:12]);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= StuckLimit) begin
          $display("tb: done, errors");
          $finish;
        end
      end
    end
  end

  task automatic add_word(input logic [7:0] rx, input logic fin, input logic empty);
    rx_backlog.push_back('{rx: rx, fin: fin, empty: empty});
    words_queued++;
  endtask

  // a response frame of the given size built to match the registers, with at
  // most one header field spoilt; a timeout word ends it instead of tlast
  task automatic send_frame(input int unsigned size, input flaw_e flaw, input bit by_timeout);
    logic [15:0] txid, proto, len;
    logic [7:0]  unit, fc;
    logic [7:0]  head [0:HeadBytes-1];
    txid = want_txid;
    proto = 16'h0000;
    len = 16'(size - 6);
    unit = want_unit;
    fc = {1'b0, want_fn};
    case (flaw)
      FLAW_TXID:      txid ^= 16'($urandom_range(1, 65535));
      FLAW_PROTOCOL:  proto = 16'($urandom_range(1, 65535));
      FLAW_LENGTH:    len ^= 16'($urandom_range(1, 65535));
      FLAW_UNIT:      unit ^= 8'($urandom_range(1, 255));
      FLAW_EXCEPTION: fc = {1'b1, want_fn};
      // anything but the request code or its exception form, bit 7 included
      FLAW_FUNCTION: begin
        do fc = 8'($urandom); while (fc[6:0] == want_fn);
      end
      default: ;
    endcase
    head = '{txid[15:8], txid[7:0], proto[15:8], proto[7:0], len[15:8], len[7:0],
             unit, fc, 8'($urandom)};
    for (int unsigned i = 0; i < size; i++)
      add_word(i < HeadBytes ? head[i] : 8'($urandom), !by_timeout && i == size - 1, 1'b0);
    if (by_timeout) add_word(8'($urandom), 1'($urandom), 1'b1);
  endtask

  task automatic wait_idle();
    while (rx_backlog.size() != 0 || s_axis_tvalid || out_words_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TRANSACTION: want_txid = value;
      CFG_UNIT:        want_unit = value[7:0];
      CFG_FUNCTION:    want_fn = value[6:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] txid, input logic [7:0] unit, input logic [6:0] fn);
    wait_idle();
    write_reg(CFG_TRANSACTION, txid);
    write_reg(CFG_UNIT, {8'h00, unit});
    write_reg(CFG_FUNCTION, {9'h000, fn});
  endtask

  initial begin : run
    int unsigned phase, frames_left, sel, n;
    flaw_e       flaw;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // registers at their reset values
    add_word(8'h00, 1'b0, 1'b1);
    send_frame(5, FLAW_NONE, 1'b0);
    send_frame(9, FLAW_NONE, 1'b0);
    send_frame(9, FLAW_EXCEPTION, 1'b0);
    send_frame(3, FLAW_NONE, 1'b1);

    words_queued = 0;
    phase = 0;
    frames_left = 0;
    while (words_queued < RandomWords) begin
      if (frames_left == 0) begin
        if (phase == 0) set_regs(16'hffff, 8'hff, 7'h7f);
        else if (phase == 1) set_regs(16'h0000, 8'h00, 7'h00);
        else set_regs(16'($urandom), 8'($urandom), 7'($urandom));
        quiet = ($urandom_range(0, 3) == 0);
        frames_left = $urandom_range(8, 30);
        phase++;
      end
      frames_left--;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        // line noise, closed by tlast or by a timeout
        n = $urandom_range(1, 12);
        for (int unsigned i = 0; i < n; i++) add_word(8'($urandom), 1'b0, 1'b0);
        if ($urandom_range(0, 1) == 1) add_word(8'($urandom), 1'b1, 1'b0);
        else add_word(8'($urandom), 1'($urandom), 1'b1);
      end else if (sel < 18) begin
        send_frame($urandom_range(0, 14), flaw_e'($urandom_range(0, 6)), 1'b1);
      end else if (sel < 26) begin
        send_frame($urandom_range(1, 8), flaw_e'($urandom_range(0, 6)), 1'b0);
      end else begin
        flaw = ($urandom_range(0, 9) < 4) ? FLAW_NONE : flaw_e'($urandom_range(1, 6));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(9, 20);
        send_frame(n, flaw, 1'b0);
      end
    end

    while (rx_backlog.size() != 0 || s_axis_tvalid || out_words_due.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
